// File: hdl/glt_pkg.sv
// Shared types and codes for the graph line token parser.
`default_nettype none
package glt_pkg;

    localparam int unsigned OP_W     = 4;
    localparam int unsigned REF_W    = 32;
    localparam int unsigned ACTION_W = 6;
    localparam int unsigned STATE_W  = 4;

    typedef enum logic [OP_W-1:0] {
        TK_WS     = 4'd0,
        TK_EOL    = 4'd1,
        TK_IDENT  = 4'd2,
        TK_STRING = 4'd3,
        TK_INT    = 4'd4,
        TK_FLOAT  = 4'd5,
        TK_TYPED  = 4'd6,
        TK_TRUE   = 4'd7,
        TK_FALSE  = 4'd8,
        TK_COLON  = 4'd9,
        TK_LARROW = 4'd10,
        TK_RARROW = 4'd11,
        TK_UNDIR  = 4'd12,
        TK_LBRACK = 4'd13,
        TK_RBRACK = 4'd14,
        TK_COMMA  = 4'd15
    } t_token;

    typedef enum logic [STATE_W-1:0] {
        ST_LB      = 4'd0,
        ST_WRONG   = 4'd1,
        ST_FIRST   = 4'd2,
        ST_NLABEL  = 4'd3,
        ST_NDEF    = 4'd4,
        ST_NPCOLON = 4'd5,
        ST_NPVAL   = 4'd6,
        ST_ESECOND = 4'd7,
        ST_EDEF    = 4'd8,
        ST_ELABEL  = 4'd9,
        ST_EPCOLON = 4'd10,
        ST_EPVAL   = 4'd11,
        ST_NLIST   = 4'd12,
        ST_ELIST   = 4'd13
    } t_state;

    typedef enum logic [ACTION_W-1:0] {
        ACT_ERROR           = 6'd0,
        ACT_NOTHING         = 6'd1,
        ACT_FINISH          = 6'd2,
        ACT_FIRST_IDENT     = 6'd3,
        ACT_FIRST_STRING    = 6'd4,
        ACT_FIRST_INT       = 6'd5,
        ACT_PROP_KEY        = 6'd6,
        ACT_DIR_LEFT        = 6'd7,
        ACT_DIR_RIGHT       = 6'd8,
        ACT_DIR_UNDIR       = 6'd9,
        ACT_NODE_LABEL      = 6'd10,
        ACT_NPROP_TYPED     = 6'd11,
        ACT_NPROP_STRING    = 6'd12,
        ACT_NPROP_INT       = 6'd13,
        ACT_NPROP_FLOAT     = 6'd14,
        ACT_NPROP_FALSE     = 6'd15,
        ACT_NPROP_TRUE      = 6'd16,
        ACT_SECOND_IDENT    = 6'd17,
        ACT_SECOND_STRING   = 6'd18,
        ACT_SECOND_INT      = 6'd19,
        ACT_EDGE_LABEL      = 6'd20,
        ACT_EPROP_TYPED     = 6'd21,
        ACT_EPROP_STRING    = 6'd22,
        ACT_EPROP_INT       = 6'd23,
        ACT_EPROP_FLOAT     = 6'd24,
        ACT_EPROP_FALSE     = 6'd25,
        ACT_EPROP_TRUE      = 6'd26,
        ACT_INIT_LIST       = 6'd27,
        ACT_LIST_TRUE       = 6'd28,
        ACT_LIST_FALSE      = 6'd29,
        ACT_LIST_STRING     = 6'd30,
        ACT_LIST_INT        = 6'd31,
        ACT_SAVE_NODE_LIST  = 6'd32,
        ACT_SAVE_EDGE_LIST  = 6'd33
    } t_action;

    typedef struct packed {
        t_action action;
        t_state  next;
        logic    error;
        logic    done;
    } t_rule;

endpackage
`default_nettype wire

// File: hdl/graph_line_token_parser.sv
// Top level of the graph line token parser: input register, rule lookup, result register.
//
// The parser takes one lexical token per request and runs the line grammar of node and
// edge import lines on it, giving one result per token: the action code, the state after
// the token, an error flag (set only on the token that first breaks the line), a
// line-done flag (set when an end of line closes a line) and the token handle unchanged.
// A token is captured in an input register, looked up against the parse state, and the
// result lands in an output register when the result slot is free. A new token is taken
// every cycle as long as results are taken; the parse-state loop is a single table
// lookup on the registered token, so the sustained rate is one token per cycle. Each
// register stage holds its request while the stage after it is stalled.
`default_nettype none
module graph_line_token_parser (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_in_valid,
    output logic                               o_in_ready,
    input  wire logic [glt_pkg::OP_W-1:0]      i_op,
    input  wire logic [glt_pkg::REF_W-1:0]     i_token_ref,
    output logic                               o_out_valid,
    input  wire logic                          i_out_ready,
    output logic [glt_pkg::ACTION_W-1:0]       o_action,
    output logic [glt_pkg::STATE_W-1:0]        o_state_after,
    output logic                               o_error_raised,
    output logic                               o_line_done,
    output logic [glt_pkg::REF_W-1:0]          o_token_ref_out
);
    import glt_pkg::*;

    // input stage
    logic              r_in_vld;
    t_token            r_in_op;
    logic [REF_W-1:0]  r_in_ref;

    // result stage
    logic              r_out_vld;
    t_action           r_out_action;
    t_state            r_out_state;
    logic              r_out_error;
    logic              r_out_done;
    logic [REF_W-1:0]  r_out_ref;

    // parse state
    t_state            r_state;
    t_state            n_state;

    t_rule             rule;
    logic              in_take;
    logic              advance;

    // advance the input stage into the result stage when the result slot frees up
    assign advance    = r_in_vld && (!r_out_vld || i_out_ready);
    assign o_in_ready = !r_in_vld || advance;
    assign in_take    = i_in_valid && o_in_ready;

    glt_rule_lookup u_rule (
        .i_state (r_state),
        .i_op    (r_in_op),
        .o_rule  (rule)
    );

    // next parse state: move only when the registered token retires into the result
    always_comb begin
        n_state = r_state;
        if (advance) begin
            n_state = rule.next;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_LB;
        end else begin
            r_state <= n_state;
        end
    end

    // input register: load on acceptance, drop when it retires without a refill
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (in_take) begin
            r_in_vld <= 1'b1;
        end else if (advance) begin
            r_in_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_op  <= t_token'(i_op);
            r_in_ref <= i_token_ref;
        end
    end

    // result register: hold while stalled downstream
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (advance) begin
            r_out_vld <= 1'b1;
        end else if (i_out_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_action <= rule.action;
            r_out_state  <= rule.next;
            r_out_error  <= rule.error;
            r_out_done   <= rule.done;
            r_out_ref    <= r_in_ref;
        end
    end

    assign o_out_valid     = r_out_vld;
    assign o_action        = r_out_action;
    assign o_state_after   = r_out_state;
    assign o_error_raised  = r_out_error;
    assign o_line_done     = r_out_done;
    assign o_token_ref_out = r_out_ref;

    // an error result always leaves the line in the wrong-line state
    a_error_to_wrong: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld && r_out_error |-> r_out_state == ST_WRONG)
        else $error("error result without wrong-line state");

    // a closed line always returns to line begin
    a_done_to_begin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld && r_out_done |-> r_out_state == ST_LB)
        else $error("line done without return to line begin");

    // the parse state tracks the state of the last retired token
    a_state_tracks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance |=> r_state == r_out_state)
        else $error("parse state diverged from last result");

    // whitespace never changes the state
    a_ws_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && r_in_op == TK_WS |=> r_out_action == ACT_NOTHING
            && r_state == $past(r_state))
        else $error("whitespace changed the parse state");

endmodule
`default_nettype wire

// File: hdl/glt_rule_lookup.sv
// Grammar rule table: current state and token kind to action and next state.
`default_nettype none
module glt_rule_lookup (
    input  glt_pkg::t_state i_state,
    input  glt_pkg::t_token i_op,
    output glt_pkg::t_rule  o_rule
);
    import glt_pkg::*;

    t_action action;
    t_state  next;

    always_comb begin
        // no rule for the pair: drop into the wrong-line state
        action = ACT_ERROR;
        next   = ST_WRONG;
        if (i_op == TK_WS) begin
            action = ACT_NOTHING;
            next   = i_state;
        end else if (i_state == ST_WRONG) begin
            if (i_op == TK_EOL) begin
                action = ACT_FINISH;
                next   = ST_LB;
            end else begin
                action = ACT_NOTHING;
                next   = ST_WRONG;
            end
        end else begin
            case (i_state)
                ST_LB: begin
                    case (i_op)
                        TK_EOL:    begin action = ACT_FINISH;       next = ST_LB;    end
                        TK_IDENT:  begin action = ACT_FIRST_IDENT;  next = ST_FIRST; end
                        TK_STRING: begin action = ACT_FIRST_STRING; next = ST_FIRST; end
                        TK_INT:    begin action = ACT_FIRST_INT;    next = ST_FIRST; end
                        default: ;
                    endcase
                end
                ST_FIRST: begin
                    case (i_op)
                        TK_COLON:  begin action = ACT_NOTHING;   next = ST_NLABEL;  end
                        TK_EOL:    begin action = ACT_FINISH;    next = ST_LB;      end
                        TK_IDENT:  begin action = ACT_PROP_KEY;  next = ST_NPCOLON; end
                        TK_LARROW: begin action = ACT_DIR_LEFT;  next = ST_ESECOND; end
                        TK_RARROW: begin action = ACT_DIR_RIGHT; next = ST_ESECOND; end
                        TK_UNDIR:  begin action = ACT_DIR_UNDIR; next = ST_ESECOND; end
                        default: ;
                    endcase
                end
                ST_NDEF: begin
                    case (i_op)
                        TK_COLON: begin action = ACT_NOTHING;  next = ST_NLABEL;  end
                        TK_IDENT: begin action = ACT_PROP_KEY; next = ST_NPCOLON; end
                        TK_EOL:   begin action = ACT_FINISH;   next = ST_LB;      end
                        default: ;
                    endcase
                end
                ST_NLABEL: begin
                    if (i_op == TK_IDENT) begin
                        action = ACT_NODE_LABEL;
                        next   = ST_NDEF;
                    end
                end
                ST_NPCOLON: begin
                    if (i_op == TK_COLON) begin
                        action = ACT_NOTHING;
                        next   = ST_NPVAL;
                    end
                end
                ST_NPVAL: begin
                    case (i_op)
                        TK_TYPED:  begin action = ACT_NPROP_TYPED;  next = ST_NDEF;  end
                        TK_STRING: begin action = ACT_NPROP_STRING; next = ST_NDEF;  end
                        TK_INT:    begin action = ACT_NPROP_INT;    next = ST_NDEF;  end
                        TK_FLOAT:  begin action = ACT_NPROP_FLOAT;  next = ST_NDEF;  end
                        TK_FALSE:  begin action = ACT_NPROP_FALSE;  next = ST_NDEF;  end
                        TK_TRUE:   begin action = ACT_NPROP_TRUE;   next = ST_NDEF;  end
                        TK_LBRACK: begin action = ACT_INIT_LIST;    next = ST_NLIST; end
                        default: ;
                    endcase
                end
                ST_ESECOND: begin
                    case (i_op)
                        TK_IDENT:  begin action = ACT_SECOND_IDENT;  next = ST_EDEF; end
                        TK_STRING: begin action = ACT_SECOND_STRING; next = ST_EDEF; end
                        TK_INT:    begin action = ACT_SECOND_INT;    next = ST_EDEF; end
                        default: ;
                    endcase
                end
                ST_EDEF: begin
                    case (i_op)
                        TK_COLON: begin action = ACT_NOTHING;  next = ST_ELABEL;  end
                        TK_EOL:   begin action = ACT_FINISH;   next = ST_LB;      end
                        TK_IDENT: begin action = ACT_PROP_KEY; next = ST_EPCOLON; end
                        default: ;
                    endcase
                end
                ST_EPCOLON: begin
                    if (i_op == TK_COLON) begin
                        action = ACT_NOTHING;
                        next   = ST_EPVAL;
                    end
                end
                ST_ELABEL: begin
                    if (i_op == TK_IDENT) begin
                        action = ACT_EDGE_LABEL;
                        next   = ST_EDEF;
                    end
                end
                ST_EPVAL: begin
                    case (i_op)
                        TK_TYPED:  begin action = ACT_EPROP_TYPED;  next = ST_EDEF;  end
                        TK_STRING: begin action = ACT_EPROP_STRING; next = ST_EDEF;  end
                        TK_INT:    begin action = ACT_EPROP_INT;    next = ST_EDEF;  end
                        TK_FLOAT:  begin action = ACT_EPROP_FLOAT;  next = ST_EDEF;  end
                        TK_FALSE:  begin action = ACT_EPROP_FALSE;  next = ST_EDEF;  end
                        TK_TRUE:   begin action = ACT_EPROP_TRUE;   next = ST_EDEF;  end
                        TK_LBRACK: begin action = ACT_INIT_LIST;    next = ST_ELIST; end
                        default: ;
                    endcase
                end
                ST_NLIST, ST_ELIST: begin
                    // no depth kept: a nested bracket restarts the list
                    case (i_op)
                        TK_TRUE:   begin action = ACT_LIST_TRUE;   next = i_state; end
                        TK_FALSE:  begin action = ACT_LIST_FALSE;  next = i_state; end
                        TK_STRING: begin action = ACT_LIST_STRING; next = i_state; end
                        TK_INT:    begin action = ACT_LIST_INT;    next = i_state; end
                        TK_LBRACK: begin action = ACT_INIT_LIST;   next = i_state; end
                        TK_COMMA:  begin action = ACT_NOTHING;     next = i_state; end
                        TK_RBRACK: begin
                            if (i_state == ST_NLIST) begin
                                action = ACT_SAVE_NODE_LIST;
                                next   = ST_NDEF;
                            end else begin
                                action = ACT_SAVE_EDGE_LIST;
                                next   = ST_EDEF;
                            end
                        end
                        default: ;
                    endcase
                end
                default: ;
            endcase
        end
    end

    assign o_rule.action = action;
    assign o_rule.next   = next;
    assign o_rule.error  = (action == ACT_ERROR);
    assign o_rule.done   = (action == ACT_FINISH);

endmodule
`default_nettype wire
